// ===== hdl/mdh_pkg.sv =====
// Shared widths, register indexes, reset values and mode codes of the movement detector.
package mdh_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned DIFF_W     = SAMPLE_W + 1;
  localparam int unsigned SUM_W      = 2 * DIFF_W;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned RAD_W      = SUM_W + FRAC_W;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned LEVEL_W    = 32;
  localparam int unsigned DECAY_W    = 16;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned ELAPSED_W  = 16;
  localparam int unsigned MAX_AXES   = 4;
  localparam int unsigned AXES_DEF   = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned IN_DATA_W  = MAX_AXES * SAMPLE_W + ELAPSED_W;
  localparam int unsigned OUT_BITS   = 2 + LEVEL_W + 2;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [LEVEL_W-1:0] UPPER_RST   = LEVEL_W'(1280);
  localparam logic [LEVEL_W-1:0] LOWER_RST   = LEVEL_W'(512);
  localparam logic [DECAY_W-1:0] DECAY_RST   = DECAY_W'(62259);
  localparam logic [TIME_W-1:0]  TIMEOUT_RST = '0;

  typedef enum logic [1:0] {
    MODE_SEEK_MOVE  = 2'd0,
    MODE_SEEK_STILL = 2'd1,
    MODE_TIMEOUT    = 2'd2
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER   = 2'd0,
    REG_LOWER   = 2'd1,
    REG_DECAY   = 2'd2,
    REG_TIMEOUT = 2'd3
  } cfg_reg_e;

endpackage

// ===== hdl/movement_detector_hysteresis.sv =====
// Movement detector: leaky motion index with a three-mode hysteresis machine.
// Each item passes the axis differences, the 25-step square root unit (skipped
// for the first item after reset) and the decision; a new item is taken once the
// previous one has left the core, so output stalls also hold back the input.
// Reset is asynchronous, active low; it restores the default registers, the
// timeout mode and a zero index.
module movement_detector_hysteresis
  import mdh_pkg::*;
#(
  parameter int unsigned AXES = AXES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // Fields from bit 0: axis_0, axis_1, axis_2, axis_3, elapsed_ms.
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // Fields from bit 0: movement_found, stillness_found, index_value, detector_mode, zero fill.
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int unsigned AX_CNT_W = (AXES > 1) ? $clog2(AXES) : 1;
  localparam int unsigned MUL_CNT_W = $clog2(DECAY_W + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DIFF   = 4'b0010,
    ST_SQRT   = 4'b0100,
    ST_DECIDE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [LEVEL_W-1:0] upper_q, lower_q;
  logic [DECAY_W-1:0] decay_q;
  logic [TIME_W-1:0]  timeout_q;

  logic signed [SAMPLE_W-1:0] cur_q  [AXES];
  logic signed [SAMPLE_W-1:0] prev_q [AXES];
  logic [ELAPSED_W-1:0]       elapsed_q;
  logic [AX_CNT_W-1:0]        ax_cnt_q;
  logic [SUM_W-1:0]           sum_q, sum_d;
  logic signed [DIFF_W-1:0]   diff;
  logic [DIFF_W-1:0]          abs_diff;
  logic                       ax_last;

  logic [DECAY_W-1:0]   mul_sh_q;
  logic [LEVEL_W-1:0]   prod_q;
  logic [LEVEL_W:0]     prod_add;
  logic [MUL_CNT_W-1:0] mul_cnt_q;

  logic              sqrt_start, sqrt_done;
  logic [ROOT_W-1:0] root;
  logic [LEVEL_W:0]  level_sum;

  logic               first_q;
  logic [LEVEL_W-1:0] level_q;
  mode_e              mode_q, mode_d;
  logic [TIME_W-1:0]  wait_q, wait_d;
  logic [TIME_W:0]    wait_sum;
  logic               moved, still;

  logic               out_valid_q, out_free;
  logic               moved_q, still_q;
  logic [LEVEL_W-1:0] index_q;
  mode_e              out_mode_q;

  logic in_take;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_take       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q   <= UPPER_RST;
      lower_q   <= LOWER_RST;
      decay_q   <= DECAY_RST;
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_UPPER:   upper_q   <= cfg_wdata_i[LEVEL_W-1:0];
        REG_LOWER:   lower_q   <= cfg_wdata_i[LEVEL_W-1:0];
        REG_DECAY:   decay_q   <= cfg_wdata_i[DECAY_W-1:0];
        REG_TIMEOUT: timeout_q <= cfg_wdata_i[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  // One axis per cycle: the head of the sample and history shift lines.
  assign diff     = DIFF_W'(cur_q[0]) - DIFF_W'(prev_q[0]);
  assign abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign sum_d    = sum_q + SUM_W'(abs_diff * abs_diff);
  assign ax_last  = (ax_cnt_q == AX_CNT_W'(AXES - 1));

  assign sqrt_start = (state_q == ST_DIFF) && ax_last && !first_q;

  mdh_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i ({sum_d, FRAC_W'(0)}),
    .done_o     (sqrt_done),
    .root_o     (root)
  );

  // Shift-add decay product, one factor bit per cycle; the dropped low bits
  // give the floor of level * decay / 2^16.
  assign prod_add  = {1'b0, prod_q} + (mul_sh_q[0] ? {1'b0, level_q} : '0);
  assign level_sum = {1'b0, prod_q} + (LEVEL_W + 1)'(root);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_take) state_d = ST_DIFF;
      ST_DIFF:   if (ax_last) state_d = first_q ? ST_DECIDE : ST_SQRT;
      ST_SQRT:   if (sqrt_done) state_d = ST_DECIDE;
      ST_DECIDE: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Hysteresis decision on the updated index.
  always_comb begin
    moved    = 1'b0;
    still    = 1'b0;
    mode_d   = mode_q;
    wait_d   = wait_q;
    wait_sum = {1'b0, wait_q} + (TIME_W + 1)'(elapsed_q);
    case (mode_q)
      MODE_SEEK_MOVE: begin
        if (level_q >= upper_q) begin
          moved  = 1'b1;
          mode_d = MODE_SEEK_STILL;
        end
      end
      MODE_SEEK_STILL: begin
        if (level_q < lower_q) begin
          still  = 1'b1;
          mode_d = MODE_TIMEOUT;
          wait_d = '0;
        end
      end
      default: begin
        wait_d = wait_sum[TIME_W] ? '1 : wait_sum[TIME_W-1:0];
        mode_d = (wait_d >= timeout_q) ? MODE_SEEK_MOVE : MODE_TIMEOUT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ax_cnt_q    <= '0;
      mul_cnt_q   <= '0;
      first_q     <= 1'b1;
      level_q     <= '0;
      mode_q      <= MODE_TIMEOUT;
      wait_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_take) begin
        ax_cnt_q <= '0;
      end else if (state_q == ST_DIFF) begin
        ax_cnt_q <= ax_cnt_q + AX_CNT_W'(1);
      end
      if (sqrt_start) begin
        mul_cnt_q <= MUL_CNT_W'(DECAY_W);
      end else if (mul_cnt_q != '0) begin
        mul_cnt_q <= mul_cnt_q - MUL_CNT_W'(1);
      end
      if ((state_q == ST_SQRT) && sqrt_done) begin
        level_q <= level_sum[LEVEL_W] ? '1 : level_sum[LEVEL_W-1:0];
      end
      if ((state_q == ST_DECIDE) && out_free) begin
        first_q     <= 1'b0;
        mode_q      <= mode_d;
        wait_q      <= wait_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      for (int k = 0; k < AXES; k++) begin
        cur_q[k] <= s_axis_tdata[k*SAMPLE_W +: SAMPLE_W];
      end
      elapsed_q <= s_axis_tdata[MAX_AXES*SAMPLE_W +: ELAPSED_W];
      sum_q     <= '0;
    end else if (state_q == ST_DIFF) begin
      // The current sample moves into the history line as it is consumed.
      for (int k = 0; k < AXES - 1; k++) begin
        cur_q[k]  <= cur_q[k+1];
        prev_q[k] <= prev_q[k+1];
      end
      prev_q[AXES-1] <= cur_q[0];
      sum_q          <= sum_d;
    end
    if (sqrt_start) begin
      mul_sh_q <= decay_q;
      prod_q   <= '0;
    end else if (mul_cnt_q != '0) begin
      mul_sh_q <= {1'b0, mul_sh_q[DECAY_W-1:1]};
      prod_q   <= prod_add[LEVEL_W:1];
    end
    if ((state_q == ST_DECIDE) && out_free) begin
      moved_q    <= moved;
      still_q    <= still;
      index_q    <= level_q;
      out_mode_q <= mode_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_W'({out_mode_q, index_q, still_q, moved_q});

endmodule

// ===== hdl/mdh_isqrt.sv =====
// Digit-serial integer square root, two radicand bits per cycle.
module mdh_isqrt
  import mdh_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  radicand_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int unsigned REM_W = ROOT_W + 2;
  localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q, rem_d, rem_sh, trial;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;

  // Bring down the next radicand pair and try to set the next root bit.
  always_comb begin
    rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
    trial  = {root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_q[ROOT_W-2:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_q[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(ROOT_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== tb/movement_detector_hysteresis_tb.sv =====
// Self-checking testbench for the movement detector with hysteresis.
`timescale 1ns / 100ps

module movement_detector_hysteresis_tb;
  import mdh_pkg::*;

  localparam int unsigned AXES_N      = AXES_DEF;
  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned DIR_SPLIT   = 9;

  typedef struct packed {
    logic [ELAPSED_W-1:0]               elapsed;
    logic [MAX_AXES-1:0][SAMPLE_W-1:0] axis;
  } sample_t;

  typedef struct packed {
    mode_e              mode;
    logic [LEVEL_W-1:0] index;
    logic               still;
    logic               moved;
  } result_t;

  typedef struct packed {
    sample_t smp;
    logic    typed;
    result_t want;
  } dir_row_t;

  typedef enum logic {
    GEN_WANDER,
    GEN_SWING
  } gen_kind_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // Fields from bit 0: axis_0, axis_1, axis_2, axis_3, elapsed_ms.
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // Fields from bit 0: movement_found, stillness_found, index_value, detector_mode, zero fill.
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  movement_detector_hysteresis #(
    .AXES(AXES_N)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow copy of the detector: registers and state.
  logic [LEVEL_W-1:0]                upper_reg = UPPER_RST;
  logic [LEVEL_W-1:0]                lower_reg = LOWER_RST;
  logic [DECAY_W-1:0]                decay_reg = DECAY_RST;
  logic [TIME_W-1:0]                 timeout_reg = TIMEOUT_RST;
  logic [MAX_AXES-1:0][SAMPLE_W-1:0] last_axis = '0;
  logic                              first_pend = 1'b1;
  logic [LEVEL_W-1:0]                level = '0;
  mode_e                             det_mode = MODE_TIMEOUT;
  logic [TIME_W-1:0]                 wait_ms = '0;

  result_t                           pending_results[$];
  dir_row_t                          dir_rows[$];
  logic [MAX_AXES-1:0][SAMPLE_W-1:0] gen_prev = '0;
  int                                send_idle_pct = 19;
  int                                recv_idle_pct = 64;
  int unsigned                       err_count = 0;
  int unsigned                       samples_sent = 0;
  int unsigned                       results_seen = 0;
  int unsigned                       moves_seen = 0;
  int unsigned                       stills_seen = 0;
  int unsigned                       cycle_count = 0;

  // Bitwise integer square root; the radicand is below 2^51.
  function automatic logic [31:0] root_of(logic [63:0] rad);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (32'd1 << i);
      if (64'(trial) * 64'(trial) <= rad) begin
        root = trial;
      end
    end
    return root;
  endfunction

  function automatic result_t advance_detector(sample_t s);
    result_t          r;
    longint           dv;
    logic [63:0]      sq_sum;
    logic [47:0]      prod;
    logic [32:0]      total;
    logic [32:0]      tsum;
    r = '0;
    if (!first_pend) begin
      sq_sum = '0;
      for (int k = 0; k < AXES_N; k++) begin
        dv = longint'($signed(s.axis[k])) - longint'($signed(last_axis[k]));
        sq_sum = sq_sum + 64'(dv * dv);
      end
      prod  = 48'(level) * 48'(decay_reg);
      total = 33'(prod >> 16) + 33'(root_of(sq_sum << 16));
      level = total[32] ? '1 : total[31:0];
    end
    first_pend = 1'b0;
    last_axis  = s.axis;
    case (det_mode)
      MODE_SEEK_MOVE: begin
        if (level >= upper_reg) begin
          r.moved  = 1'b1;
          det_mode = MODE_SEEK_STILL;
        end
      end
      MODE_SEEK_STILL: begin
        if (level < lower_reg) begin
          r.still  = 1'b1;
          det_mode = MODE_TIMEOUT;
          wait_ms  = '0;
        end
      end
      default: begin
        tsum     = 33'(wait_ms) + 33'(s.elapsed);
        wait_ms  = tsum[32] ? '1 : tsum[31:0];
        det_mode = (wait_ms >= timeout_reg) ? MODE_SEEK_MOVE : MODE_TIMEOUT;
      end
    endcase
    r.index = level;
    r.mode  = det_mode;
    return r;
  endfunction

  function automatic dir_row_t row(int a0, int a1, int a2, int a3, int el, bit typed,
                                   bit mv, bit st, int unsigned idx, mode_e md);
    dir_row_t d;
    d.smp.axis[0]  = 16'(a0);
    d.smp.axis[1]  = 16'(a1);
    d.smp.axis[2]  = 16'(a2);
    d.smp.axis[3]  = 16'(a3);
    d.smp.elapsed  = 16'(el);
    d.typed        = typed;
    d.want.moved   = mv;
    d.want.still   = st;
    d.want.index   = idx;
    d.want.mode    = md;
    return d;
  endfunction

  function automatic sample_t make_sample(gen_kind_e kind);
    sample_t s;
    int      pick;
    pick      = $urandom_range(99);
    s.elapsed = ($urandom_range(99) < 85) ? 16'($urandom_range(0, 300)) : 16'($urandom);
    for (int k = 0; k < MAX_AXES; k++) begin
      if (k >= AXES_N) begin
        s.axis[k] = 16'($urandom);
      end else if (kind == GEN_SWING && pick < 90) begin
        s.axis[k] = gen_prev[0][15] ? 16'h7FFF : 16'h8000;
      end else if (pick < 60) begin
        s.axis[k] = gen_prev[k] + 16'($urandom_range(0, 16)) - 16'd8;
      end else if (pick < 85) begin
        s.axis[k] = gen_prev[k] + 16'($urandom_range(0, 4096)) - 16'd2048;
      end else begin
        s.axis[k] = 16'($urandom);
      end
    end
    return s;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  task automatic check_result(result_t got);
    result_t want;
    results_seen++;
    if (got.moved) moves_seen++;
    if (got.still) stills_seen++;
    if (pending_results.size() == 0) begin
      $error("result with no sample outstanding: %h", got);
      err_count++;
    end else begin
      want = pending_results.pop_front();
      check_field("movement_found", 32'(want.moved), 32'(got.moved));
      check_field("stillness_found", 32'(want.still), 32'(got.still));
      check_field("index_value", want.index, got.index);
      check_field("detector_mode", 32'(want.mode), 32'(got.mode));
    end
  endtask

  // Sender: optional gap, then hold the item until it is taken.
  task automatic push_sample(sample_t s, logic typed, result_t want);
    result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 48)) @(posedge clk_i);
    end
    s_axis_tdata  <= s;
    s_axis_tvalid <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!s_axis_tready);
    r = advance_detector(s);
    pending_results.push_back(typed ? want : r);
    gen_prev = s.axis;
    samples_sent++;
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    case (idx)
      REG_UPPER: upper_reg   = v;
      REG_LOWER: lower_reg   = v;
      REG_DECAY: decay_reg   = v[DECAY_W-1:0];
      default:   timeout_reg = v;
    endcase
  endtask

  task automatic apply_settings(logic [31:0] up, logic [31:0] lo, logic [31:0] dec,
                                logic [31:0] tmo);
    write_reg(REG_UPPER, up);
    write_reg(REG_LOWER, lo);
    write_reg(REG_DECAY, dec);
    write_reg(REG_TIMEOUT, tmo);
    cfg_we_i <= 1'b0;
  endtask

  // Thresholds sized so that jitter and bursts cross them both ways.
  task automatic apply_random_settings(bit full_decay);
    logic [31:0] up;
    logic [31:0] lo;
    logic [31:0] dec;
    up  = $urandom_range(1000, 200000);
    lo  = $urandom_range(100, up);
    dec = full_decay ? $urandom : {16'($urandom), 16'($urandom_range(0, 58982))};
    apply_settings(up, lo, dec, $urandom_range(0, 2000));
  endtask

  task automatic run_random(gen_kind_e kind, int n);
    for (int i = 0; i < n; i++) begin
      push_sample(make_sample(kind), 1'b0, '0);
    end
    drain();
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      check_result(result_t'(m_axis_tdata[$bits(result_t)-1:0]));
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("movement_detector_hysteresis_tb failed");
      $finish;
    end
  end

  initial begin
    // Reset values: first sample only primes, then a full-scale step on axis 0.
    dir_rows.push_back(row(0, 0, 0, 0, 5, 1, 0, 0, 0, MODE_SEEK_MOVE));
    dir_rows.push_back(row(0, 0, 0, 0, 0, 1, 0, 0, 0, MODE_SEEK_MOVE));
    dir_rows.push_back(row(32767, 0, 0, 0, 0, 1, 1, 0, 8388352, MODE_SEEK_STILL));
    dir_rows.push_back(row(-32768, 0, 0, 'h7FFF, 0, 0, 0, 0, 0, MODE_SEEK_MOVE));
    dir_rows.push_back(row(-32768, -32768, -32768, -32768, 65535, 0, 0, 0, 0, MODE_SEEK_MOVE));
    dir_rows.push_back(row(32767, 32767, 32767, 32767, 0, 0, 0, 0, 0, MODE_SEEK_MOVE));
    dir_rows.push_back(row('h5555, 'hAAAA, 'h5555, 'hAAAA, 'h5555, 0, 0, 0, 0, MODE_SEEK_MOVE));
    dir_rows.push_back(row('hAAAA, 'h5555, 'hAAAA, 'h5555, 'hAAAA, 0, 0, 0, 0, MODE_SEEK_MOVE));
    dir_rows.push_back(row(0, 0, 0, 0, 0, 0, 0, 0, 0, MODE_SEEK_MOVE));
    // No decay, timeout of 100 ms: threshold boundaries and timer accumulation.
    // The sample that enters timeout carries a huge elapsed time that must not count.
    dir_rows.push_back(row(0, 0, 0, 0, 65535, 1, 0, 1, 0, MODE_TIMEOUT));
    dir_rows.push_back(row(0, 0, 0, 0, 60, 1, 0, 0, 0, MODE_TIMEOUT));
    dir_rows.push_back(row(0, 0, 0, 0, 40, 1, 0, 0, 0, MODE_SEEK_MOVE));
    dir_rows.push_back(row(0, 5, 0, 0, 0, 1, 1, 0, 1280, MODE_SEEK_STILL));
    dir_rows.push_back(row(0, 5, 2, 0, 0, 1, 0, 0, 512, MODE_SEEK_STILL));
    dir_rows.push_back(row(0, 6, 2, 0, 0, 1, 0, 1, 256, MODE_TIMEOUT));
    dir_rows.push_back(row(0, 6, 2, 0, 99, 1, 0, 0, 0, MODE_TIMEOUT));
    dir_rows.push_back(row(0, 6, 2, 0, 1, 1, 0, 0, 0, MODE_SEEK_MOVE));
    dir_rows.push_back(row(3, 10, 2, -1, 0, 1, 1, 0, 1280, MODE_SEEK_STILL));
    dir_rows.push_back(row(3, 10, 2, 0, 0, 1, 0, 1, 0, MODE_TIMEOUT));
    dir_rows.push_back(row(3, 10, 2, 0, 100, 1, 0, 0, 0, MODE_SEEK_MOVE));
    dir_rows.push_back(row(3, 10, 3, 0, 0, 1, 0, 0, 256, MODE_SEEK_MOVE));
    dir_rows.push_back(row(4, 11, 4, 0, 0, 1, 0, 0, 443, MODE_SEEK_MOVE));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (i == DIR_SPLIT) begin
        drain();
        // Upper half of the decay word must be dropped by the block.
        apply_settings(UPPER_RST, LOWER_RST, 32'hABCD_0000, 32'd100);
      end
      push_sample(dir_rows[i].smp, dir_rows[i].typed, dir_rows[i].want);
    end
    drain();

    apply_random_settings(1'b0);
    run_random(GEN_WANDER, 130);

    send_idle_pct = 64;
    recv_idle_pct = 19;
    // Lowest upper and highest lower threshold with no timeout: modes rotate.
    apply_settings('0, '1, $urandom, '0);
    run_random(GEN_WANDER, 60);
    // Slowest leak and full-scale swings drive the index into saturation.
    apply_settings('1, '0, '1, '0);
    run_random(GEN_SWING, 200);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    apply_random_settings(1'b0);
    run_random(GEN_WANDER, 70);
    apply_settings('0, '1, $urandom, '1);
    run_random(GEN_WANDER, 30);
    apply_random_settings(1'b1);
    run_random(GEN_WANDER, 40);

    repeat (40) @(posedge clk_i);
    $display("Sent %0d samples and checked %0d results (%0d movement, %0d stillness).",
             samples_sent, results_seen, moves_seen, stills_seen);
    $display("Covered threshold boundaries, timeout extremes and index saturation.");
    if (err_count == 0) begin
      $display("movement_detector_hysteresis_tb passed");
    end else begin
      $display("movement_detector_hysteresis_tb failed");
    end
    $finish;
  end

endmodule
